FILE: hw/rtl/mwalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwalu_pkg
// Shared types and constants of the multi-width integer ALU.
// ----------------------------------------------------------------------------
package mwalu_pkg;

    localparam int DataW   = 64;
    localparam int DivDepth = DataW;   // one divider cell per quotient bit

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_NEG = 3'd5,
        OP_SHL = 3'd6,
        OP_SAR = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2,
        W64 = 2'd3
    } wsel_t;

    // Data that travels along the cell row with one request.
    typedef struct packed {
        logic             vld;
        logic             is_div;     // divide or modulo
        logic             is_quo;     // divide (quotient wanted)
        logic             neg_res;    // negate the magnitude at the end
        logic             dz;
        logic [1:0]       wsel;
        logic [DataW-1:0] rem;        // partial remainder
        logic [DataW-1:0] quo;        // dividend shifting out / quotient in
        logic [DataW-1:0] dvs;        // divisor magnitude
        logic [DataW-1:0] res;        // finished result of non-divide ops
    } cell_t;

    function automatic logic [DataW-1:0] sext_w(input logic [DataW-1:0] v,
                                                 input logic [1:0] ws);
        logic [DataW-1:0] r;
        begin
            case (ws)
                W8:      r = {{(DataW-8){v[7]}}, v[7:0]};
                W16:     r = {{(DataW-16){v[15]}}, v[15:0]};
                W32:     r = {{(DataW-32){v[31]}}, v[31:0]};
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/mwalu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwalu_front
// Decode stage: sign-extends operands, computes add/sub/neg/shift results,
// prepares divider magnitudes and a 3-part multiply.
// ----------------------------------------------------------------------------
module mwalu_front
    import mwalu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  logic [2:0]       op,
    input  logic [1:0]       wsel,
    input  logic [DataW-1:0] a_in,
    input  logic [DataW-1:0] b_in,
    output cell_t            cell_out
);

    logic [DataW-1:0] a, b, cnt, ma, mb, shl_r, sar_r, res;
    logic [6:0]       wbits;
    logic             big;
    logic [DataW-1:0] mul_r;
    cell_t            cell_reg, cell_next;

    // 32x32 partial products; only the low 64 bits of the product are kept
    logic [DataW-1:0] p_ll, p_lh, p_hl;

    always_comb begin
        a     = sext_w(a_in, wsel);
        b     = sext_w(b_in, wsel);
        wbits = 7'd8 << wsel;
        case (wsel)
            W8:      cnt = {56'd0, b_in[7:0]};
            W16:     cnt = {48'd0, b_in[15:0]};
            W32:     cnt = {32'd0, b_in[31:0]};
            default: cnt = b_in;
        endcase
        big   = cnt >= {57'd0, wbits};
        shl_r = big ? '0 : (a << cnt[5:0]);
        sar_r = big ? {DataW{a[DataW-1]}} : DataW'($signed(a) >>> cnt[5:0]);
        ma    = a[DataW-1] ? (~a + 1'b1) : a;
        mb    = b[DataW-1] ? (~b + 1'b1) : b;
        p_ll  = a[31:0] * b[31:0];
        p_lh  = a[31:0] * b[63:32];
        p_hl  = a[63:32] * b[31:0];
        mul_r = p_ll + {p_lh[31:0] + p_hl[31:0], 32'd0};
        case (op_t'(op))
            OP_ADD:  res = a + b;
            OP_SUB:  res = a - b;
            OP_MUL:  res = mul_r;
            OP_NEG:  res = ~a + 1'b1;
            OP_SHL:  res = shl_r;
            OP_SAR:  res = sar_r;
            default: res = '0;
        endcase

        cell_next.vld     = in_vld;
        cell_next.is_div  = (op_t'(op) == OP_DIV) || (op_t'(op) == OP_MOD);
        cell_next.is_quo  = op_t'(op) == OP_DIV;
        cell_next.dz      = cell_next.is_div && (b == '0);
        cell_next.neg_res = (op_t'(op) == OP_DIV) ? (a[DataW-1] ^ b[DataW-1])
                                                  : a[DataW-1];
        cell_next.wsel    = wsel;
        cell_next.rem     = '0;
        cell_next.quo     = ma;
        cell_next.dvs     = mb;
        cell_next.res     = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg.vld <= cell_next.vld;
        end
        if (en) begin
            cell_reg.is_div  <= cell_next.is_div;
            cell_reg.is_quo  <= cell_next.is_quo;
            cell_reg.neg_res <= cell_next.neg_res;
            cell_reg.dz      <= cell_next.dz;
            cell_reg.wsel    <= cell_next.wsel;
            cell_reg.rem     <= cell_next.rem;
            cell_reg.quo     <= cell_next.quo;
            cell_reg.dvs     <= cell_next.dvs;
            cell_reg.res     <= cell_next.res;
        end
    end

    assign cell_out = cell_reg;

endmodule

FILE: hw/rtl/mwalu_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwalu_div_cell
// One restoring-division step: shifts in one dividend bit, compares with the
// divisor, subtracts and records one quotient bit. Other ops pass through.
// ----------------------------------------------------------------------------
module mwalu_div_cell
    import mwalu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cell_t cell_in,
    output cell_t cell_out
);

    cell_t            cell_reg, cell_next;
    logic [DataW:0]   trial;
    logic [DataW:0]   diff;

    always_comb begin
        cell_next = cell_in;
        trial     = {cell_in.rem, cell_in.quo[DataW-1]};
        diff      = trial - {1'b0, cell_in.dvs};
        if (cell_in.is_div) begin
            if (!diff[DataW]) begin
                cell_next.rem = diff[DataW-1:0];
                cell_next.quo = {cell_in.quo[DataW-2:0], 1'b1};
            end else begin
                cell_next.rem = trial[DataW-1:0];
                cell_next.quo = {cell_in.quo[DataW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg.vld <= cell_next.vld;
        end
        if (en) begin
            cell_reg.is_div  <= cell_next.is_div;
            cell_reg.is_quo  <= cell_next.is_quo;
            cell_reg.neg_res <= cell_next.neg_res;
            cell_reg.dz      <= cell_next.dz;
            cell_reg.wsel    <= cell_next.wsel;
            cell_reg.rem     <= cell_next.rem;
            cell_reg.quo     <= cell_next.quo;
            cell_reg.dvs     <= cell_next.dvs;
            cell_reg.res     <= cell_next.res;
        end
    end

    assign cell_out = cell_reg;

endmodule

FILE: hw/rtl/multi_width_integer_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_width_integer_alu
// Signed 8/16/32/64-bit integer ALU with a pipelined divider cell row.
// ----------------------------------------------------------------------------
// Every request flows through a fixed pipeline of 66 registers: one decode
// stage, 64 division cells (one quotient bit per cell) and one output stage,
// which each request passes in that order. One request is taken every
// cycle while the row is not held: the whole row advances together and
// holds when the output register is full and m_ready is low.
module multi_width_integer_alu
    import mwalu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_op,
    input  logic [1:0]              s_width_sel,
    input  logic signed [DataW-1:0] s_operand_a,
    input  logic signed [DataW-1:0] s_operand_b,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DataW-1:0] m_result,
    output logic                    m_write_result,
    output logic                    m_div_by_zero
);

    cell_t            row [0:DivDepth];
    logic             en;
    logic             out_vld_reg;
    logic [DataW-1:0] out_res_reg, mag, fin;
    logic             out_wr_reg, out_dz_reg;
    cell_t            last;

    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    mwalu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .op       (s_op),
        .wsel     (s_width_sel),
        .a_in     (s_operand_a),
        .b_in     (s_operand_b),
        .cell_out (row[0])
    );

    for (genvar i = 0; i < DivDepth; i++) begin : g_cell
        mwalu_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (row[i]),
            .cell_out (row[i+1])
        );
    end

    assign last = row[DivDepth];

    always_comb begin
        mag = last.is_quo ? last.quo : last.rem;
        if (last.dz) begin
            fin = '0;
        end else if (last.is_div) begin
            fin = sext_w(last.neg_res ? (~mag + 1'b1) : mag, last.wsel);
        end else begin
            fin = sext_w(last.res, last.wsel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= last.vld;
        end
        if (en) begin
            out_res_reg <= fin;
            out_wr_reg  <= !last.dz;
            out_dz_reg  <= last.dz;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_result       = out_res_reg;
    assign m_write_result = out_wr_reg;
    assign m_div_by_zero  = out_dz_reg;

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_write_result != m_div_by_zero))
        else $error("write and zero-divide flags disagree");
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_div_by_zero) |-> (m_result == '0))
        else $error("zero-divide result not cleared");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result)))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule
